// File: src/record_length_framing_check_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the record length framing check unit
// Immediate-consequence and next-cycle properties, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RECORD_LENGTH_FRAMING_CHECK_UNIT_ASSERT_SVH
`define RECORD_LENGTH_FRAMING_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication
`define RLFC_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RLFC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rlfc_pkg.sv
// ----------------------------------------------------------------------------
// rlfc_pkg
// Shared widths, header geometry and the types passed between modules.
// ----------------------------------------------------------------------------
package rlfc_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int HDR_POS_W   = 4;
    // header length in bytes, 2 to 16; the last two hold the payload length
    localparam int HEADER_BYTES = 5;

    localparam logic [HDR_POS_W-1:0] HDR_LAST   = HDR_POS_W'(HEADER_BYTES - 1);
    localparam logic [HDR_POS_W-1:0] HDR_LEN_HI = HDR_POS_W'(HEADER_BYTES - 2);
    localparam logic [COUNT_W-1:0]   COUNT_MAX  = {COUNT_W{1'b1}};

    // one word handed to the parser
    typedef struct packed {
        logic              fire;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } rlfc_step_t;

    // verdict for the word being parsed
    typedef struct packed {
        logic               framing_ok;
        logic [COUNT_W-1:0] record_count;
    } rlfc_result_t;

endpackage

// File: src/rlfc_if.sv
// ----------------------------------------------------------------------------
// rlfc channel interfaces
// Valid/ready channels for incoming buffer words and outgoing verdicts.
// ----------------------------------------------------------------------------
interface rlfc_byte_if;
    logic                       valid;
    logic                       ready;
    logic [rlfc_pkg::BYTE_W-1:0] data_byte;
    logic                       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rlfc_result_if;
    logic                        valid;
    logic                        ready;
    logic [rlfc_pkg::COUNT_W-1:0] record_count;
    logic                        framing_ok;

    modport source (output valid, output record_count, output framing_ok, input ready);
    modport sink   (input valid, input record_count, input framing_ok, output ready);
endinterface

// File: src/rlfc_parser.sv
// ----------------------------------------------------------------------------
// rlfc_parser
// Header walk, payload skip and saturating record count, one word per step.
// ----------------------------------------------------------------------------
module rlfc_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rlfc_pkg::rlfc_step_t   step,
    output rlfc_pkg::rlfc_result_t result
);

    logic [rlfc_pkg::HDR_POS_W-1:0] header_position_reg, header_position_next;
    logic [rlfc_pkg::BYTE_W-1:0]    length_upper_reg, length_upper_next;
    logic [rlfc_pkg::COUNT_W-1:0]   payload_left_reg, payload_left_next;
    logic                           in_payload_reg, in_payload_next;
    logic [rlfc_pkg::COUNT_W-1:0]   records_seen_reg, records_seen_next;

    logic [rlfc_pkg::COUNT_W-1:0]   left_dec;
    logic [rlfc_pkg::COUNT_W-1:0]   length;
    logic                           at_boundary;

    assign left_dec = payload_left_reg - 1'b1;
    assign length   = {length_upper_reg, step.data_byte};

    // next state for the current word
    always_comb
    begin
        header_position_next = header_position_reg;
        length_upper_next    = length_upper_reg;
        payload_left_next    = payload_left_reg;
        in_payload_next      = in_payload_reg;
        records_seen_next    = records_seen_reg;
        at_boundary          = 1'b0;

        if (in_payload_reg)
        begin
            payload_left_next = left_dec;
            in_payload_next   = (left_dec != '0);
            at_boundary       = (left_dec == '0);
        end
        else if (header_position_reg >= rlfc_pkg::HDR_LAST)
        begin
            // header complete: count it, load payload length
            if (records_seen_reg != rlfc_pkg::COUNT_MAX)
            begin
                records_seen_next = records_seen_reg + 1'b1;
            end
            header_position_next = '0;
            length_upper_next    = '0;
            payload_left_next    = length;
            in_payload_next      = (length != '0);
            at_boundary          = (length == '0);
        end
        else
        begin
            if (header_position_reg == rlfc_pkg::HDR_LEN_HI)
            begin
                length_upper_next = step.data_byte;
            end
            header_position_next = header_position_reg + 1'b1;
        end

        result.framing_ok   = at_boundary;
        result.record_count = at_boundary ? records_seen_next : '0;

        // end of buffer: start fresh
        if (step.last_byte)
        begin
            header_position_next = '0;
            length_upper_next    = '0;
            payload_left_next    = '0;
            in_payload_next      = 1'b0;
            records_seen_next    = '0;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_position_reg <= '0;
            length_upper_reg    <= '0;
            payload_left_reg    <= '0;
            in_payload_reg      <= 1'b0;
            records_seen_reg    <= '0;
        end
        else if (step.fire)
        begin
            header_position_reg <= header_position_next;
            length_upper_reg    <= length_upper_next;
            payload_left_reg    <= payload_left_next;
            in_payload_reg      <= in_payload_next;
            records_seen_reg    <= records_seen_next;
        end
    end

endmodule

// File: src/record_length_framing_check_unit.sv
// ----------------------------------------------------------------------------
// record_length_framing_check_unit
// Checks that a byte stream of length-prefixed records ends on a boundary.
// ----------------------------------------------------------------------------
// Usage:
//   stream carries one buffer word per handshake; last_byte flags the final
//   word of a buffer. Each record is a header whose last two words give the
//   payload length, high word first, followed by that many payload words.
//   report carries one verdict per buffer: framing_ok and record_count
//   (count is zero on failure, saturates at 65535 otherwise).
//   Throughput: one word per cycle unless a last word is stalled; the parser
//   state updates from the input register, so consecutive words need no gap.
//   Verdict path: a last word passes the input register, then the result
//   register, before its verdict shows on report.
//   Stall: non-last words keep flowing while a verdict waits; a last word
//   waits in the input register until the result register is free, and
//   stream.ready drops only then.
//   Reset: clears the parser state and both valid flags; the next word
//   starts a new buffer. After every last word the state clears as well.
// ----------------------------------------------------------------------------
module record_length_framing_check_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    rlfc_byte_if.sink            stream,
    rlfc_result_if.source        report
);

    logic                          s1_valid_reg;
    logic [rlfc_pkg::BYTE_W-1:0]   s1_data_reg;
    logic                          s1_last_reg;

    logic                          out_valid_reg;
    logic [rlfc_pkg::COUNT_W-1:0]  out_count_reg;
    logic                          out_ok_reg;

    logic                          out_free;
    logic                          s1_fire;
    rlfc_pkg::rlfc_step_t          step;
    rlfc_pkg::rlfc_result_t        result;

    // handshake
    assign out_free     = !out_valid_reg || report.ready;
    assign s1_fire      = s1_valid_reg && (!s1_last_reg || out_free);
    assign stream.ready = !s1_valid_reg || s1_fire;

    assign step.fire      = s1_fire;
    assign step.data_byte = s1_data_reg;
    assign step.last_byte = s1_last_reg;

    rlfc_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            s1_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            s1_data_reg <= stream.data_byte;
            s1_last_reg <= stream.last_byte;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_count_reg <= result.record_count;
            out_ok_reg    <= result.framing_ok;
        end
    end

    assign report.valid        = out_valid_reg;
    assign report.record_count = out_count_reg;
    assign report.framing_ok   = out_ok_reg;

endmodule

// File: src/rlfc_checker.sv
// ----------------------------------------------------------------------------
// rlfc_checker
// Port-level checks on the framing check unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "record_length_framing_check_unit_assert.svh"

module rlfc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [rlfc_pkg::COUNT_W-1:0] record_count,
    input logic                         framing_ok
);

    // a stalled verdict holds
    `RLFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(record_count) && $stable(framing_ok), "verdict changed while stalled")

    // failure carries a zero count
    `RLFC_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && !framing_ok, record_count == '0, "failure with nonzero count")

    // a good buffer holds at least one record
    `RLFC_ASSERT_NOW(a_ok_nonzero, clk, rst_n, out_valid && framing_ok, record_count != '0, "good framing with zero records")

    // with no verdict pending, input is never blocked
    `RLFC_ASSERT_NOW(a_ready_free, clk, rst_n, !out_valid, in_ready, "input stalled with free result slot")

endmodule

bind record_length_framing_check_unit rlfc_checker u_rlfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (stream.ready),
    .out_valid    (report.valid),
    .out_ready    (report.ready),
    .record_count (report.record_count),
    .framing_ok   (report.framing_ok)
);
